// ----- rtl/arrt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package arrt_pkg;

	// Default number of region slots in the table.
	localparam int REGION_SLOTS_DEF = 256;

	// Operation codes carried on the operation port.
	localparam logic [1:0] OP_TRACK   = 2'd0;
	localparam logic [1:0] OP_UNTRACK = 2'd1;
	localparam logic [1:0] OP_QUERY   = 2'd2;

	// One stored region.
	typedef struct packed {
		logic [63:0] start;
		logic [63:0] length;
		logic [2:0]  prot;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MOVE
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/address_range_region_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Address region table.
// A transaction is accepted at a rising clock edge where start is high and busy is low.
// operation selects track (append a region), untrack (drop every region overlapping the
// given range) or query (protection of the first region that fully contains the range).
// Every transaction produces exactly one result, presented on found, found_protection,
// accepted and region_count for one cycle while done is high; the receiver cannot stall.
// Track and the unused operation code finish without a scan. A query reads the occupied
// slots one by one and stops at the first that contains the range. An untrack inspects
// every occupied slot in turn, with an extra move step for each removed region
// that is replaced by the last entry, since that entry is fetched from the region memory
// and written into the freed slot before it is checked again. The single read port of the
// region memory forces this one-slot-at-a-time scan. A new transaction can be accepted
// in the cycle in which the previous result is shown. Reset empties the table
// (region count zero); the region memory itself is not cleared, since only occupied slots
// are ever read.
module address_range_region_table #(
	parameter int REGION_SLOTS = arrt_pkg::REGION_SLOTS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	output logic       busy,
	input  wire [1:0]  operation,
	input  wire [63:0] range_start,
	input  wire [63:0] range_length,
	input  wire [2:0]  protection,
	output logic       done,
	output logic       found,
	output logic [2:0] found_protection,
	output logic       accepted,
	output logic [8:0] region_count
);

	localparam int AW = $clog2(REGION_SLOTS);
	localparam int CW = $clog2(REGION_SLOTS + 1);

	arrt_pkg::state_t state_q, state_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [CW-1:0]    idx_q, idx_d;
	logic [1:0]       op_q;
	logic [63:0]      s_q;
	logic [63:0]      end_q;
	logic             done_q;
	logic             found_q;
	logic [2:0]       fprot_q;
	logic             acc_q;

	// Memory port controls.
	logic             we_c;
	logic [AW-1:0]    waddr_c;
	arrt_pkg::entry_t wdata_c;
	logic             re_c;
	logic [AW-1:0]    raddr_c;
	arrt_pkg::entry_t rdata;

	// Result of the current cycle.
	logic             fin_c;
	logic             found_c;
	logic [2:0]       fprot_c;
	logic             acc_c;

	logic [CW-1:0]    idx_nx_c;
	logic [CW-1:0]    cnt_dec_c;
	logic [63:0]      reg_end_c;
	logic             contains_c;
	logic             overlaps_c;

	arrt_mem #(
		.DEPTH(REGION_SLOTS),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (we_c),
		.waddr(waddr_c),
		.wdata(wdata_c),
		.re   (re_c),
		.raddr(raddr_c),
		.rdata(rdata)
	);

	assign idx_nx_c  = idx_q + 1'b1;
	assign cnt_dec_c = cnt_q - 1'b1;

	// Region end wraps modulo 2^64, like the range end captured at acceptance.
	assign reg_end_c  = rdata.start + rdata.length;
	assign contains_c = (rdata.start <= s_q) && (end_q <= reg_end_c);
	assign overlaps_c = (rdata.start < end_q) && (s_q < reg_end_c);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		idx_d   = idx_q;
		we_c    = 1'b0;
		waddr_c = cnt_q[AW-1:0];
		wdata_c = '{start: range_start, length: range_length, prot: protection};
		re_c    = 1'b0;
		raddr_c = '0;
		fin_c   = 1'b0;
		found_c = 1'b0;
		fprot_c = 3'd0;
		acc_c   = 1'b0;
		unique case (state_q)
			arrt_pkg::ST_IDLE: begin
				if (start) begin
					unique case (operation)
						arrt_pkg::OP_TRACK: begin
							fin_c = 1'b1;
							if (range_start != 64'd0 && cnt_q < CW'(REGION_SLOTS)) begin
								we_c  = 1'b1;
								cnt_d = cnt_q + 1'b1;
								acc_c = 1'b1;
							end
						end
						arrt_pkg::OP_UNTRACK, arrt_pkg::OP_QUERY: begin
							if (cnt_q == '0) begin
								fin_c = 1'b1;
							end else begin
								// Fetch slot zero; its data is compared in the next cycle.
								re_c    = 1'b1;
								idx_d   = '0;
								state_d = arrt_pkg::ST_SCAN;
							end
						end
						default: begin
							fin_c = 1'b1;
						end
					endcase
				end
			end
			arrt_pkg::ST_SCAN: begin
				// The read data holds slot idx_q.
				if (op_q == arrt_pkg::OP_QUERY) begin
					if (contains_c) begin
						fin_c   = 1'b1;
						found_c = 1'b1;
						fprot_c = rdata.prot;
						state_d = arrt_pkg::ST_IDLE;
					end else if (idx_nx_c == cnt_q) begin
						fin_c   = 1'b1;
						state_d = arrt_pkg::ST_IDLE;
					end else begin
						idx_d   = idx_nx_c;
						re_c    = 1'b1;
						raddr_c = idx_nx_c[AW-1:0];
					end
				end else begin
					if (overlaps_c) begin
						cnt_d = cnt_dec_c;
						if (idx_q == cnt_dec_c) begin
							// The dropped region was the last one: nothing to move.
							fin_c   = 1'b1;
							state_d = arrt_pkg::ST_IDLE;
						end else begin
							// Fetch the last entry to fill the freed slot.
							re_c    = 1'b1;
							raddr_c = cnt_dec_c[AW-1:0];
							state_d = arrt_pkg::ST_MOVE;
						end
					end else if (idx_nx_c == cnt_q) begin
						fin_c   = 1'b1;
						state_d = arrt_pkg::ST_IDLE;
					end else begin
						idx_d   = idx_nx_c;
						re_c    = 1'b1;
						raddr_c = idx_nx_c[AW-1:0];
					end
				end
			end
			arrt_pkg::ST_MOVE: begin
				// The read data now holds the moved entry. It is written into the freed
				// slot and stays in the read register, so the next scan cycle checks it
				// again without a new read.
				we_c    = 1'b1;
				waddr_c = idx_q[AW-1:0];
				wdata_c = rdata;
				state_d = arrt_pkg::ST_SCAN;
			end
			default: begin
				state_d = arrt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arrt_pkg::ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			done_q  <= fin_c;
		end
	end

	// Transaction operands and result payload.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q  <= operation;
			s_q   <= range_start;
			end_q <= range_start + range_length;
		end
		if (fin_c) begin
			found_q <= found_c;
			fprot_q <= fprot_c;
			acc_q   <= acc_c;
		end
	end

	assign busy             = (state_q != arrt_pkg::ST_IDLE);
	assign done             = done_q;
	assign found            = found_q;
	assign found_protection = fprot_q;
	assign accepted         = acc_q;
	assign region_count     = 9'(cnt_q);

	// A result is only shown once the block has returned to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy)
		else $error("result shown while busy");

	// The region count never exceeds the table size.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(REGION_SLOTS))
		else $error("region count beyond table size");

	// A move always follows a scan cycle that found an overlap.
	a_move_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == arrt_pkg::ST_MOVE) |-> ($past(state_q) == arrt_pkg::ST_SCAN))
		else $error("move without preceding scan");

	// A stored region raises the count by exactly one.
	a_track_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && acc_q) |-> (cnt_q == CW'($past(cnt_q) + 1'b1)))
		else $error("track did not advance the region count");

	// A result never reports both a stored region and a containment hit.
	a_result_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(found_q && acc_q))
		else $error("result flags both found and accepted");

endmodule

`default_nettype wire

// ----- rtl/arrt_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Region storage: one write port and one read port with registered read data.
// The read data holds its value in cycles without a read.
module arrt_mem #(
	parameter int DEPTH = arrt_pkg::REGION_SLOTS_DEF,
	parameter int AW    = $clog2(arrt_pkg::REGION_SLOTS_DEF)
) (
	input  wire                  clk,
	input  wire                  we,
	input  wire [AW-1:0]         waddr,
	input  arrt_pkg::entry_t     wdata,
	input  wire                  re,
	input  wire [AW-1:0]         raddr,
	output arrt_pkg::entry_t     rdata
);

	arrt_pkg::entry_t mem [DEPTH];
	arrt_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- verif/address_range_region_table_test.sv -----
`timescale 1ns / 1ps

module address_range_region_table_test;

	import arrt_pkg::*;

	// Operation code 3 has no function in the block; it must leave the table alone.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Number of random transactions that follow the directed opening.
	localparam int unsigned RANDOM_ITEMS = 1330;

	// Most regions live in a 64 KiB window low in the address space, so that they overlap
	// and contain each other often. A second window sits at the very top of the address
	// space, where region ends wrap past zero.
	localparam logic [63:0] LOW_WINDOW  = 64'h0000_0000_0040_0000;
	localparam logic [63:0] HIGH_WINDOW = 64'hFFFF_FFFF_FFFF_0000;
	localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

	// One result as the block presents it; the field order matches the concatenation of
	// the result ports used by the result monitor below.
	typedef struct packed {
		logic       found;
		logic [2:0] prot;
		logic       accepted;
		logic [8:0] count;
	} region_result_t;

	// Keeps a private copy of the region table, works out the result of every accepted
	// transaction and holds the results that the block still owes.
	class region_table_scoreboard;
		logic [63:0]    base_addr [REGION_SLOTS_DEF];
		logic [63:0]    span [REGION_SLOTS_DEF];
		logic [2:0]     prot_code [REGION_SLOTS_DEF];
		int unsigned    held;
		region_result_t owed [$];
		int unsigned    mismatches;

		function new();
			held = 0;
			mismatches = 0;
		endfunction

		function void note_transaction(logic [1:0] op, logic [63:0] s, logic [63:0] n,
				logic [2:0] p);
			region_result_t r;
			logic [63:0]    range_end;
			int unsigned    i;
			int unsigned    c;
			r = '0;
			range_end = s + n;
			case (op)
				OP_TRACK: begin
					if (s != 64'd0 && held < REGION_SLOTS_DEF) begin
						base_addr[held] = s;
						span[held] = n;
						prot_code[held] = p;
						held++;
						r.accepted = 1'b1;
					end
				end
				OP_UNTRACK: begin
					// A freed slot takes the last entry, which is then tested in its place.
					i = 0;
					c = held;
					while (i < c) begin
						if (base_addr[i] < range_end && s < base_addr[i] + span[i]) begin
							c--;
							base_addr[i] = base_addr[c];
							span[i] = span[c];
							prot_code[i] = prot_code[c];
						end else begin
							i++;
						end
					end
					held = c;
				end
				OP_QUERY: begin
					for (i = 0; i < held && !r.found; i++) begin
						if (base_addr[i] <= s && range_end <= base_addr[i] + span[i]) begin
							r.found = 1'b1;
							r.prot = prot_code[i];
						end
					end
				end
				default: begin
				end
			endcase
			r.count = held[8:0];
			owed.push_back(r);
		endfunction

		function void check_result(region_result_t got);
			region_result_t want;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing outstanding: found=%0d prot=%0d acc=%0d count=%0d",
						$realtime, got.found, got.prot, got.accepted, got.count);
				return;
			end
			want = owed.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch found %0d/%0d prot %0d/%0d acc %0d/%0d count %0d/%0d (exp/act)",
						$realtime, want.found, got.found, want.prot, got.prot,
						want.accepted, got.accepted, want.count, got.count);
			end
		endfunction

		function void region_at(int unsigned idx, output logic [63:0] a, output logic [63:0] l);
			a = base_addr[idx];
			l = span[idx];
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  operation;
	logic [63:0] range_start;
	logic [63:0] range_length;
	logic [2:0]  protection;
	logic        done;
	logic        found;
	logic [2:0]  found_protection;
	logic        accepted;
	logic [8:0]  region_count;

	region_table_scoreboard tracker;

	// When set, the sender leaves random idle cycles before a transaction.
	bit gaps_enabled;

	address_range_region_table dut (
		.clk,
		.arst_n,
		.start,
		.busy,
		.operation,
		.range_start,
		.range_length,
		.protection,
		.done,
		.found,
		.found_protection,
		.accepted,
		.region_count
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The block gives exactly one result per transaction and the receiver cannot stall, so
	// every cycle with done high is checked against the oldest outstanding result. Outputs
	// are read right after the rising edge, which yields the values held at that edge.
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_result({found, found_protection, accepted, region_count});
	end

	// Presents one transaction and returns right after the edge that accepted it. While the
	// sender idles, the payload ports carry random values that the block must ignore. The
	// transaction is noted only once accepted, so the copy of the table follows the block.
	task automatic send_item(logic [1:0] op, logic [63:0] s, logic [63:0] n, logic [2:0] p);
		if (gaps_enabled) begin
			while ($urandom_range(0, 99) < 7) begin
				start <= 1'b0;
				operation <= 2'($urandom_range(0, 3));
				range_start <= {$urandom, $urandom};
				range_length <= {$urandom, $urandom};
				protection <= 3'($urandom_range(0, 7));
				@(posedge clk);
			end
		end
		start <= 1'b1;
		operation <= op;
		range_start <= s;
		range_length <= n;
		protection <= p;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		tracker.note_transaction(op, s, n, p);
	endtask

	// Start addresses: mostly the low window, some at the top of the address space where
	// ends wrap, and a few anywhere so that every address bit toggles.
	function automatic logic [63:0] any_start();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 82)
			return LOW_WINDOW + 64'($urandom_range(0, 32'hFFFF));
		else if (pick < 94)
			return HIGH_WINDOW + 64'($urandom_range(0, 32'hFFFF));
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] any_length();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 84)
			return 64'($urandom_range(0, 32'h7FF));
		else if (pick < 94)
			return 64'($urandom_range(0, 32'hFFFF));
		return {$urandom, $urandom};
	endfunction

	// Picks a range that lies in, or just runs past the end of, a region that the table
	// holds right now, so that queries hit and untracks remove something.
	task automatic near_region(output logic [63:0] s, output logic [63:0] n);
		logic [63:0] a;
		logic [63:0] l;
		logic [63:0] rest;
		logic [63:0] off;
		tracker.region_at($urandom_range(0, tracker.held - 1), a, l);
		off = (l > 64'hFFFF) ? 64'($urandom_range(0, 32'hFFFF)) : 64'($urandom_range(0, l[31:0]));
		rest = l - off;
		s = a + off;
		n = (rest > 64'hFFFF) ? 64'($urandom_range(0, 32'hFFFF))
			: 64'($urandom_range(0, rest[31:0]));
		if ($urandom_range(0, 9) == 0)
			n = n + 64'd1;
	endtask

	// The random part alternates between filling the table, mostly with track transactions,
	// until it is full (plus a few track attempts against a full table), and a mixed phase
	// of tracks, untracks and queries in which the table slowly drains. Regions whose end
	// wraps to zero can never be untracked, so the mixed phase also ends after a while.
	task automatic run_random();
		logic [1:0]  op;
		logic [63:0] s;
		logic [63:0] n;
		logic [2:0]  p;
		int unsigned roll;
		bit          filling;
		int unsigned full_tail;
		int unsigned phase_items;
		filling = 1'b1;
		full_tail = 6;
		phase_items = 0;
		for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
			// A long stretch in the middle runs without any idle cycles.
			gaps_enabled = !(k >= 450 && k < 750);
			phase_items++;
			if (filling && tracker.held == REGION_SLOTS_DEF) begin
				if (full_tail == 0) begin
					filling = 1'b0;
					phase_items = 0;
				end else begin
					full_tail--;
				end
			end else if (!filling && (tracker.held < 40 || phase_items > 400)) begin
				filling = 1'b1;
				full_tail = 6;
				phase_items = 0;
			end
			roll = $urandom_range(0, 99);
			s = any_start();
			n = any_length();
			p = 3'($urandom_range(0, 7));
			if (filling)
				op = (roll < 88) ? OP_TRACK : OP_QUERY;
			else if (roll < 38)
				op = OP_TRACK;
			else if (roll < 53)
				op = OP_UNTRACK;
			else if (roll < 97)
				op = OP_QUERY;
			else
				op = OP_UNUSED;
			if (op == OP_TRACK && $urandom_range(0, 49) == 0)
				s = 64'd0;
			if (op == OP_UNTRACK && $urandom_range(0, 99) < 85)
				n = 64'($urandom_range(0, 32'h3F));
			if ((op == OP_UNTRACK || op == OP_QUERY) && tracker.held > 0
					&& $urandom_range(0, 99) < 60)
				near_region(s, n);
			send_item(op, s, n, p);
		end
	endtask

	initial begin
		tracker = new();
		gaps_enabled = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_TRACK;
		range_start = 64'd0;
		range_length = 64'd0;
		protection = 3'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Operations on an empty table, the unused code and a rejected zero start.
		send_item(OP_QUERY, 64'd0, 64'd0, 3'd0);
		send_item(OP_UNTRACK, 64'd0, ALL_ONES, 3'd0);
		send_item(OP_UNUSED, ALL_ONES, ALL_ONES, 3'd7);
		send_item(OP_TRACK, 64'd0, 64'h100, 3'd6);

		// Extreme regions: one whose end wraps exactly to zero and one at the top address.
		// Neither can ever be removed again, and both stay in the two lowest slots.
		send_item(OP_TRACK, 64'd1, ALL_ONES, 3'd7);
		send_item(OP_TRACK, ALL_ONES, 64'd0, 3'd0);
		send_item(OP_TRACK, 64'h1000, 64'h100, 3'd5);
		send_item(OP_TRACK, 64'h1000, 64'h200, 3'd3);

		// The first containing region in slot order wins; a zero-length range; a range whose
		// end is zero after wrapping; a range that wraps past the top of the address space.
		send_item(OP_QUERY, 64'h1000, 64'h100, 3'd0);
		send_item(OP_QUERY, 64'h1080, 64'h100, 3'd0);
		send_item(OP_QUERY, 64'h1000, 64'd0, 3'd0);
		send_item(OP_QUERY, 64'h10, 64'hFFFF_FFFF_FFFF_FFF0, 3'd0);
		send_item(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20, 3'd0);
		send_item(OP_UNUSED, 64'd0, 64'd0, 3'd0);

		// Removing a region pulls the last one into its slot, and that one overlaps too.
		send_item(OP_UNTRACK, 64'h1050, 64'h10, 3'd0);
		send_item(OP_QUERY, 64'h1000, 64'h10, 3'd0);

		// A zero-length untrack at a region's first byte, a range that only abuts a region,
		// and a removal whose moved-in entry survives the second test.
		send_item(OP_TRACK, 64'h2000, 64'h1000, 3'd1);
		send_item(OP_TRACK, 64'h2800, 64'h10, 3'd2);
		send_item(OP_TRACK, 64'h5000, 64'h10, 3'd4);
		send_item(OP_UNTRACK, 64'h2800, 64'd0, 3'd0);
		send_item(OP_UNTRACK, 64'h4FFF, 64'd1, 3'd0);
		send_item(OP_UNTRACK, 64'h5000, 64'd1, 3'd0);
		send_item(OP_QUERY, 64'h2800, 64'h10, 3'd0);

		run_random();
		start <= 1'b0;

		// Wait for every outstanding result, then a little longer to catch stray results.
		while (tracker.owed.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("address_range_region_table_test OK");
		else
			$display("address_range_region_table_test NOT OK");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run, where every transaction is a full untrack.
	initial begin
		#50_000_000;
		$display("address_range_region_table_test NOT OK");
		$finish;
	end

endmodule
